>>> rtl/mcfb_pkg.sv
// Shared types and constants of the motor command frame builder.
package mcfb_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 10;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  // Byte positions inside a frame
  localparam logic [IDX_W-1:0] POS_ADDR     = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_OPCODE   = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_SPEED_HI = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_SPEED_LO = IDX_W'(3);

  // Reflected CRC-8 polynomial, initial value zero
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register file
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_OPCODE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_OPCODE   = CFG_IDX_W'(2);

  localparam logic [14:0] SPEED_LIMIT_RST     = 15'd330;
  localparam logic [7:0]  VELOCITY_OPCODE_RST = 8'd100;
  localparam logic [7:0]  STATUS_OPCODE_RST   = 8'd116;

  // Request kinds carried in tuser
  typedef enum logic {
    REQ_VELOCITY = 1'b0,
    REQ_STATUS   = 1'b1
  } req_type_e;

  // One classified command waiting for serialization
  typedef struct packed {
    logic        is_vel;
    logic [7:0]  addr;
    logic [7:0]  opcode;
    logic [15:0] speed;
  } frame_cmd_t;

endpackage

>>> rtl/mcfb_front.sv
// Front end: accepts commands, clamps and rounds the speed, pushes frame commands.
module mcfb_front #(
  parameter int SPEED_FRAC_BITS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic [14:0]         speed_limit_i,
  input  logic [7:0]          velocity_opcode_i,
  input  logic [7:0]          status_opcode_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output mcfb_pkg::frame_cmd_t push_data_o
);

  localparam int CW = (SPEED_FRAC_BITS + 17 > 21) ? SPEED_FRAC_BITS + 17 : 21;
  localparam logic [CW-1:0] HALF = CW'((1 << SPEED_FRAC_BITS) >> 1);

  logic [7:0]    in_addr;
  logic [19:0]   in_speed;
  logic          in_vel;
  logic [CW-1:0] v_ext;
  logic [CW-1:0] abs_v;
  logic [CW-1:0] lim;
  logic [CW-1:0] mag;
  logic          accept;

  logic          st_valid_q, st_valid_d;
  logic [7:0]    st_addr_q;
  logic [7:0]    st_op_q;
  logic          st_vel_q;
  logic          st_neg_q;
  logic [CW-1:0] st_mag_q;

  logic [CW-1:0] rnd_sum;
  logic [CW-1:0] rnd_whole;
  logic [15:0]   word;

  // Unpack and classify the incoming command
  assign in_addr  = s_axis_tdata[7:0];
  assign in_speed = s_axis_tdata[27:8];
  assign in_vel   = (mcfb_pkg::req_type_e'(s_axis_tuser) == mcfb_pkg::REQ_VELOCITY);

  // Clamp the magnitude to the limit in fixed point
  assign v_ext  = {{(CW-20){in_speed[19]}}, in_speed};
  assign abs_v  = v_ext[CW-1] ? (~v_ext + CW'(1)) : v_ext;
  assign lim    = CW'(speed_limit_i) << SPEED_FRAC_BITS;
  assign mag    = (abs_v > lim) ? lim : abs_v;

  assign s_axis_tready = !st_valid_q || push_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Hold stage valid until the queue takes the command
  always_comb begin
    st_valid_d = st_valid_q;
    if (accept) begin
      st_valid_d = 1'b1;
    end else if (push_ready_i) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_addr_q <= in_addr;
      st_op_q   <= in_vel ? velocity_opcode_i : status_opcode_i;
      st_vel_q  <= in_vel;
      st_neg_q  <= v_ext[CW-1];
      st_mag_q  <= mag;
    end
  end

  // Round half away from zero and restore the sign
  assign rnd_sum   = st_mag_q + HALF;
  assign rnd_whole = rnd_sum >> SPEED_FRAC_BITS;
  assign word      = st_neg_q ? (~rnd_whole[15:0] + 16'd1) : rnd_whole[15:0];

  assign push_valid_o       = st_valid_q;
  assign push_data_o.is_vel = st_vel_q;
  assign push_data_o.addr   = st_addr_q;
  assign push_data_o.opcode = st_op_q;
  assign push_data_o.speed  = word;

endmodule

>>> rtl/mcfb_queue.sv
// Short command queue between the front end and the frame serializer.
module mcfb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  mcfb_pkg::frame_cmd_t push_data_i,
  output logic                 head_valid_o,
  input  logic                 pop_i,
  output mcfb_pkg::frame_cmd_t head_data_o
);

  localparam int DEPTH = mcfb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mcfb_pkg::frame_cmd_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic push;
  logic pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && head_valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/mcfb_back.sv
// Back end: serializes one frame command into bytes and appends the CRC-8.
module mcfb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  mcfb_pkg::frame_cmd_t head_data_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,
  output logic                 m_axis_tlast
);

  logic [mcfb_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [7:0] crc_q, crc_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       load;
  logic       at_last;
  logic [7:0] byte_sel;

  // One byte of reflected CRC-8 update
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ mcfb_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign load    = head_valid_i && (!out_valid_q || m_axis_tready);
  assign at_last = (idx_q == mcfb_pkg::LAST_IDX);
  assign pop_o   = load && at_last;

  // Pick the byte for the current frame position
  always_comb begin
    byte_sel = 8'h00;
    if (at_last) begin
      byte_sel = crc_q;
    end else if (idx_q == mcfb_pkg::POS_ADDR) begin
      byte_sel = head_data_i.addr;
    end else if (idx_q == mcfb_pkg::POS_OPCODE) begin
      byte_sel = head_data_i.opcode;
    end else if (idx_q == mcfb_pkg::POS_SPEED_HI && head_data_i.is_vel) begin
      byte_sel = head_data_i.speed[15:8];
    end else if (idx_q == mcfb_pkg::POS_SPEED_LO && head_data_i.is_vel) begin
      byte_sel = head_data_i.speed[7:0];
    end
  end

  // Advance position and CRC on each byte loaded; after the CRC byte reset both
  always_comb begin
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (at_last) begin
        idx_d = '0;
        crc_d = mcfb_pkg::CRC_INIT;
      end else begin
        idx_d = idx_q + mcfb_pkg::IDX_W'(1);
        crc_d = crc8_step(crc_q, byte_sel);
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      crc_q       <= mcfb_pkg::CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_sel;
      out_last_q <= at_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/motor_command_frame_builder.sv
// A command passes the front-end stage register, the queue and the back-end output register;
// then one byte a cycle while m_axis_tready is high, ten bytes per frame.
// A two-entry queue lets the front accept commands while the back still sends a frame.
// The CRC byte follows the ninth byte directly; a queued next frame follows without a gap.
// Reset (rst_ni low, asynchronous) empties the pipeline and queue and loads register defaults.
// Top level: configuration registers, front end, command queue and frame serializer.
module motor_command_frame_builder #(
  parameter int SPEED_FRAC_BITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [7:0] motor_address, [27:8] target_speed, [31:28] zero
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast
);

  logic [14:0] speed_limit_q;
  logic [7:0]  velocity_opcode_q;
  logic [7:0]  status_opcode_q;

  logic                 push_valid;
  logic                 push_ready;
  mcfb_pkg::frame_cmd_t push_data;
  logic                 head_valid;
  logic                 pop;
  mcfb_pkg::frame_cmd_t head_data;

  // Write configuration registers, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q     <= mcfb_pkg::SPEED_LIMIT_RST;
      velocity_opcode_q <= mcfb_pkg::VELOCITY_OPCODE_RST;
      status_opcode_q   <= mcfb_pkg::STATUS_OPCODE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == mcfb_pkg::CFG_SPEED_LIMIT) begin
        speed_limit_q <= cfg_data_i;
      end else if (cfg_index_i == mcfb_pkg::CFG_VELOCITY_OPCODE) begin
        velocity_opcode_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == mcfb_pkg::CFG_STATUS_OPCODE) begin
        status_opcode_q <= cfg_data_i[7:0];
      end
    end
  end

  mcfb_front #(
    .SPEED_FRAC_BITS(SPEED_FRAC_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .speed_limit_i    (speed_limit_q),
    .velocity_opcode_i(velocity_opcode_q),
    .status_opcode_i  (status_opcode_q),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_data_o      (push_data)
  );

  mcfb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .head_valid_o(head_valid),
    .pop_i       (pop),
    .head_data_o (head_data)
  );

  mcfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

>>> rtl/mcfb_checker.sv
// Port-level checker for the motor command frame builder, with its bind.
module mcfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [mcfb_pkg::IDX_W-1:0] pos_q;
  logic [3:0] pending_q;
  logic in_xfer;
  logic out_xfer;
  logic frame_done;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_xfer   = m_axis_tvalid && m_axis_tready;
  assign frame_done = out_xfer && m_axis_tlast;

  // Track byte position and commands not yet fully sent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pending_q <= '0;
    end else begin
      if (out_xfer) begin
        pos_q <= (pos_q == mcfb_pkg::LAST_IDX) ? '0 : pos_q + mcfb_pkg::IDX_W'(1);
      end
      if (in_xfer && !frame_done) begin
        pending_q <= pending_q + 4'd1;
      end else if (frame_done && !in_xfer) begin
        pending_q <= pending_q - 4'd1;
      end
    end
  end

  // tlast marks exactly the tenth byte of each frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (m_axis_tlast == (pos_q == mcfb_pkg::LAST_IDX)))
    else $error("tlast out of place in frame");

  // Bytes between the speed and the CRC are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && pos_q > mcfb_pkg::POS_SPEED_LO && pos_q != mcfb_pkg::LAST_IDX)
      |-> (m_axis_tdata == 8'h00))
    else $error("nonzero padding byte");

  // Output only shows data for a command that was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pending_q != 4'd0))
    else $error("output without pending command");

  // A stalled output byte holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output changed");

endmodule

bind motor_command_frame_builder mcfb_checker u_mcfb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
